FILE: hdl/lrs_pkg.sv
package lrs_pkg;

  localparam int unsigned LineW = 63;
  localparam int unsigned CtxW = 32;
  localparam int unsigned MaxRangesDef = 64;
  localparam logic [LineW-1:0] LineMax = {LineW{1'b1}};

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdAdd = 2'd1;
  localparam logic [1:0] CmdFinal = 2'd2;
  localparam logic [1:0] CmdQuery = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBad = 2'd2;
  localparam logic [1:0] StNoFin = 2'd3;

  localparam logic CfgBefore = 1'b0;
  localparam logic CfgAfter = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WID_RD,
    S_WID_WR,
    S_SRT_RD,
    S_SRT_KEY,
    S_SRT_CMP,
    S_SRT_PUT,
    S_MRG_RD,
    S_MRG_LD,
    S_MRG_STEP,
    S_MRG_END,
    S_Q_RD,
    S_Q_CHK
  } state_t;

endpackage

FILE: hdl/lrs_ram.sv
module lrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/line_range_selector.sv
// channel | dir | beat fields (lsb first)
// in_     | in  | tdata: command[1:0] start_line[64:2] end_line[127:65] query_line[190:128]
// out_    | out | tdata: status[1:0] selected[2] past_all[3] first_line[66:4]
//         |     |        last_line[129:67] merged_count[136:130]
// cfg_    | in  | index 0 context_before, index 1 context_after
// clear, add, empty finalize and short queries load the result at the accept edge
// query: one setup read, then a scan of the entries in order up to the entry that decides
// finalize: widen each entry (read, write), insertion sort by start for each key past the first
//   (read, key, compare per shift, put), merge (read, load, a step per later entry, end)
// reset clears count and flags; the range memory is never cleared, only entries below
//   the count are used; in_tready is low from accept until the result beat is taken
module line_range_selector #(
  parameter int unsigned MAX_RANGES = lrs_pkg::MaxRangesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // command, start_line, end_line, query_line
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // status, selected, past_all, first_line, last_line, merged_count
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned LW = lrs_pkg::LineW;
  localparam int unsigned RW = 2 * LW;

  lrs_pkg::state_t state_r, state_nxt;

  logic [lrs_pkg::CtxW-1:0] ctx_b_r, ctx_a_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic fin_r, fin_nxt, all_r, all_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [LW-1:0] ks_r, ks_nxt, ke_r, ke_nxt;   // sort key / merge accumulator
  logic [LW-1:0] ln_r, ln_nxt;
  logic [LW-1:0] fst_r, fst_nxt;
  logic [LW-1:0] last_r, last_nxt;             // end of the last merged range
  logic [136:0] res_r, res_nxt;
  logic ov_r, ov_nxt;

  // memory: {end, start}
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [LW-1:0] rs, re;

  assign rs = rdata[LW-1:0];
  assign re = rdata[RW-1:LW];

  lrs_ram #(.WIDTH(RW), .DEPTH(MAX_RANGES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [1:0] cmd;
  logic [LW-1:0] in_s, in_e, in_l;
  assign cmd = in_tdata[1:0];
  assign in_s = in_tdata[64:2];
  assign in_e = in_tdata[127:65];
  assign in_l = in_tdata[190:128];

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // index helpers
  logic [CW-1:0] i_inc, im1, j_inc, jm1, jm2;
  logic i_last;
  assign i_inc = i_r + CW'(1);
  assign im1 = i_r - CW'(1);
  assign j_inc = j_r + CW'(1);
  assign jm1 = j_r - CW'(1);
  assign jm2 = j_r - CW'(2);
  assign i_last = (i_inc == cnt_r);

  // widen with start clamped at 1 and end saturating
  logic [LW-1:0] wid_s, wid_e;
  always_comb begin
    wid_s = (rs <= LW'(ctx_b_r)) ? LW'(1) : rs - LW'(ctx_b_r);
    wid_e = (re >= lrs_pkg::LineMax - LW'(ctx_a_r)) ? lrs_pkg::LineMax : re + LW'(ctx_a_r);
  end

  // merge: next range overlaps or touches the accumulator
  logic [LW:0] ke_p1;
  logic touch;
  assign ke_p1 = {1'b0, ke_r} + (LW+1)'(1);
  assign touch = ({1'b0, rs} <= ke_p1);

  // query: entry starts past the line, holds it, or is the last one
  logic q_stop, q_hit;
  assign q_hit = !(ln_r < rs) && (ln_r <= re);
  assign q_stop = (ln_r < rs) || (ln_r <= re) || i_last;

  assign in_tready = (state_r == lrs_pkg::S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, res_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrs_pkg::S_IDLE: begin
        if (in_beat) begin
          if (cmd == lrs_pkg::CmdFinal && !all_r) state_nxt = lrs_pkg::S_WID_RD;
          else if (cmd == lrs_pkg::CmdQuery && fin_r && !all_r) state_nxt = lrs_pkg::S_Q_RD;
        end
      end
      lrs_pkg::S_WID_RD: state_nxt = lrs_pkg::S_WID_WR;
      lrs_pkg::S_WID_WR: begin
        if (!i_last) state_nxt = lrs_pkg::S_WID_RD;
        else if (cnt_r == CW'(1)) state_nxt = lrs_pkg::S_MRG_RD;
        else state_nxt = lrs_pkg::S_SRT_RD;
      end
      lrs_pkg::S_SRT_RD: state_nxt = lrs_pkg::S_SRT_KEY;
      lrs_pkg::S_SRT_KEY: state_nxt = lrs_pkg::S_SRT_CMP;
      lrs_pkg::S_SRT_CMP: begin
        if (!(rs > ks_r) || jm1 == '0) state_nxt = lrs_pkg::S_SRT_PUT;
      end
      lrs_pkg::S_SRT_PUT: state_nxt = i_last ? lrs_pkg::S_MRG_RD : lrs_pkg::S_SRT_RD;
      lrs_pkg::S_MRG_RD: state_nxt = lrs_pkg::S_MRG_LD;
      lrs_pkg::S_MRG_LD: begin
        state_nxt = (cnt_r == CW'(1)) ? lrs_pkg::S_MRG_END : lrs_pkg::S_MRG_STEP;
      end
      lrs_pkg::S_MRG_STEP: begin
        if (i_last) state_nxt = lrs_pkg::S_MRG_END;
      end
      lrs_pkg::S_MRG_END: state_nxt = lrs_pkg::S_IDLE;
      lrs_pkg::S_Q_RD: state_nxt = lrs_pkg::S_Q_CHK;
      lrs_pkg::S_Q_CHK: begin
        if (q_stop) state_nxt = lrs_pkg::S_IDLE;
      end
      default: state_nxt = lrs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r; fin_nxt = fin_r; all_nxt = all_r;
    i_nxt = i_r; j_nxt = j_r; ks_nxt = ks_r; ke_nxt = ke_r; ln_nxt = ln_r;
    fst_nxt = fst_r; last_nxt = last_r; res_nxt = res_r;
    ov_nxt = ov_r && !out_tready;
    we = 1'b0; waddr = i_r[AW-1:0]; wdata = {ke_r, ks_r}; raddr = i_r[AW-1:0];
    unique case (state_r)
      lrs_pkg::S_IDLE: begin
        if (in_beat) begin
          res_nxt = '0;
          i_nxt = '0;
          ln_nxt = in_l;
          unique case (cmd)
            lrs_pkg::CmdClear: begin
              cnt_nxt = '0; fin_nxt = 1'b0; all_nxt = 1'b1;
              ov_nxt = 1'b1;
            end
            lrs_pkg::CmdAdd: begin
              ov_nxt = 1'b1;
              if (in_s == '0 || in_e < in_s) res_nxt[1:0] = lrs_pkg::StBad;
              else if (cnt_r >= CW'(MAX_RANGES)) res_nxt[1:0] = lrs_pkg::StFull;
              else begin
                we = 1'b1; waddr = cnt_r[AW-1:0]; wdata = {in_e, in_s};
                cnt_nxt = cnt_r + CW'(1); all_nxt = 1'b0; fin_nxt = 1'b0;
              end
            end
            lrs_pkg::CmdFinal: begin
              fin_nxt = 1'b1;
              // empty table matches every line
              if (all_r) begin
                ov_nxt = 1'b1;
                res_nxt[66:4] = LW'(1);
                res_nxt[129:67] = lrs_pkg::LineMax;
              end
            end
            default: begin
              // query
              if (!fin_r) begin
                ov_nxt = 1'b1;
                res_nxt[1:0] = lrs_pkg::StNoFin;
              end else if (all_r) begin
                ov_nxt = 1'b1;
                res_nxt[2] = 1'b1;
              end
            end
          endcase
        end
      end
      lrs_pkg::S_WID_WR: begin
        we = 1'b1; wdata = {wid_e, wid_s};
        i_nxt = i_last ? CW'(1) : i_inc;
      end
      lrs_pkg::S_SRT_KEY: begin
        // rdata is key i; fetch entry i-1
        ks_nxt = rs; ke_nxt = re;
        j_nxt = i_r;
        raddr = im1[AW-1:0];
      end
      lrs_pkg::S_SRT_CMP: begin
        // rdata is entry j-1; move it up while it starts above the key
        if (rs > ks_r) begin
          we = 1'b1; waddr = j_r[AW-1:0]; wdata = rdata;
          j_nxt = jm1;
          raddr = jm2[AW-1:0];
        end
      end
      lrs_pkg::S_SRT_PUT: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = {ke_r, ks_r};
        i_nxt = i_inc;
      end
      lrs_pkg::S_MRG_RD: raddr = '0;
      lrs_pkg::S_MRG_LD: begin
        ks_nxt = rs; ke_nxt = re; fst_nxt = rs;
        j_nxt = '0; i_nxt = CW'(1);
        raddr = AW'(1);
      end
      lrs_pkg::S_MRG_STEP: begin
        if (touch) begin
          if (re > ke_r) ke_nxt = re;
        end else begin
          we = 1'b1; waddr = j_r[AW-1:0]; wdata = {ke_r, ks_r};
          j_nxt = j_inc;
          ks_nxt = rs; ke_nxt = re;
        end
        i_nxt = i_inc;
        raddr = i_inc[AW-1:0];
      end
      lrs_pkg::S_MRG_END: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = {ke_r, ks_r};
        cnt_nxt = j_inc;
        last_nxt = ke_r;
        ov_nxt = 1'b1;
        res_nxt[66:4] = fst_r;
        res_nxt[129:67] = ke_r;
        res_nxt[136:130] = 7'(j_inc);
      end
      lrs_pkg::S_Q_CHK: begin
        if (q_stop) begin
          ov_nxt = 1'b1;
          res_nxt[2] = q_hit;
          res_nxt[3] = (ln_r > last_r);
        end else begin
          i_nxt = i_inc;
          raddr = i_inc[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrs_pkg::S_IDLE;
      ctx_b_r <= '0; ctx_a_r <= '0;
      cnt_r <= '0; fin_r <= 1'b0; all_r <= 1'b1; ov_r <= 1'b0;
      i_r <= '0; j_r <= '0; ks_r <= '0; ke_r <= '0;
      ln_r <= '0; fst_r <= '0; last_r <= '0; res_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lrs_pkg::CfgBefore) ctx_b_r <= cfg_wdata;
        else ctx_a_r <= cfg_wdata;
      end
      state_r <= state_nxt;
      cnt_r <= cnt_nxt; fin_r <= fin_nxt; all_r <= all_nxt; ov_r <= ov_nxt;
      i_r <= i_nxt; j_r <= j_nxt; ks_r <= ks_nxt; ke_r <= ke_nxt;
      ln_r <= ln_nxt; fst_r <= fst_nxt; last_r <= last_nxt; res_r <= res_nxt;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned TableDepth = lrs_pkg::MaxRangesDef;
  localparam int unsigned StallLimit = 200000;

  // the fields of one result beat
  typedef struct packed {
    logic [1:0]               status;
    logic                     selected;
    logic                     past_all;
    logic [lrs_pkg::LineW-1:0] first_line;
    logic [lrs_pkg::LineW-1:0] last_line;
    logic [6:0]               merged_count;
  } selection_t;

  // holds a software copy of the range table and the results it predicts
  class range_table_board;
    logic [lrs_pkg::LineW-1:0] starts[TableDepth];
    logic [lrs_pkg::LineW-1:0] ends[TableDepth];
    int unsigned              count;
    bit                       finalized;
    bit                       match_all;
    logic [lrs_pkg::CtxW-1:0]  ctx_before;
    logic [lrs_pkg::CtxW-1:0]  ctx_after;
    selection_t               pending[$];
    int unsigned              errors;

    function new();
      count = 0;
      finalized = 0;
      match_all = 1;
      ctx_before = '0;
      ctx_after = '0;
      errors = 0;
    endfunction

    function void set_context(logic idx, logic [lrs_pkg::CtxW-1:0] val);
      if (idx == lrs_pkg::CfgBefore) ctx_before = val;
      else ctx_after = val;
    endfunction

    // widen by context, insertion sort by start, merge overlapping or touching
    function void widen_and_merge();
      logic [lrs_pkg::LineW-1:0] s, e;
      int unsigned i, j;
      for (i = 0; i < count; i++) begin
        s = starts[i];
        e = ends[i];
        starts[i] = (s <= lrs_pkg::LineW'(ctx_before)) ? lrs_pkg::LineW'(1)
                                                        : s - lrs_pkg::LineW'(ctx_before);
        ends[i] = (e >= lrs_pkg::LineMax - lrs_pkg::LineW'(ctx_after)) ? lrs_pkg::LineMax
                                                                        : e + lrs_pkg::LineW'(ctx_after);
      end
      for (i = 1; i < count; i++) begin
        s = starts[i];
        e = ends[i];
        j = i;
        while (j > 0 && starts[j-1] > s) begin
          starts[j] = starts[j-1];
          ends[j] = ends[j-1];
          j--;
        end
        starts[j] = s;
        ends[j] = e;
      end
      if (count == 0) return;
      j = 0;
      for (i = 1; i < count; i++) begin
        if ({1'b0, starts[i]} <= {1'b0, ends[j]} + 64'd1) begin
          if (ends[i] > ends[j]) ends[j] = ends[i];
        end else begin
          j++;
          starts[j] = starts[i];
          ends[j] = ends[i];
        end
      end
      count = j + 1;
    endfunction

    function void note_beat(logic [1:0] cmd, logic [lrs_pkg::LineW-1:0] s,
                            logic [lrs_pkg::LineW-1:0] e, logic [lrs_pkg::LineW-1:0] ln);
      selection_t r;
      int unsigned i;
      r = '0;
      case (cmd)
        lrs_pkg::CmdClear: begin
          count = 0;
          finalized = 0;
          match_all = 1;
        end
        lrs_pkg::CmdAdd: begin
          if (s < 1 || e < s) r.status = lrs_pkg::StBad;
          else if (count >= TableDepth) r.status = lrs_pkg::StFull;
          else begin
            starts[count] = s;
            ends[count] = e;
            count++;
            match_all = 0;
            finalized = 0;
          end
        end
        lrs_pkg::CmdFinal: begin
          if (!match_all) widen_and_merge();
          finalized = 1;
          if (match_all || count == 0) begin
            r.first_line = 1;
            r.last_line = lrs_pkg::LineMax;
          end else begin
            r.first_line = starts[0];
            r.last_line = ends[count-1];
            r.merged_count = 7'(count);
          end
        end
        default: begin
          if (!finalized) r.status = lrs_pkg::StNoFin;
          else if (match_all) r.selected = 1;
          else begin
            for (i = 0; i < count; i++) begin
              if (ln < starts[i]) break;
              if (ln <= ends[i]) begin
                r.selected = 1;
                break;
              end
            end
            if (count == 0 || ln > ends[count-1]) r.past_all = 1;
          end
        end
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(selection_t got);
      selection_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.selected !== want.selected) begin
        $error("selected expected %0d actual %0d", want.selected, got.selected);
        errors++;
      end
      if (got.past_all !== want.past_all) begin
        $error("past_all expected %0d actual %0d", want.past_all, got.past_all);
        errors++;
      end
      if (got.first_line !== want.first_line) begin
        $error("first_line expected %0d actual %0d", want.first_line, got.first_line);
        errors++;
      end
      if (got.last_line !== want.last_line) begin
        $error("last_line expected %0d actual %0d", want.last_line, got.last_line);
        errors++;
      end
      if (got.merged_count !== want.merged_count) begin
        $error("merged_count expected %0d actual %0d", want.merged_count,
               got.merged_count);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;   // command, start_line, end_line, query_line
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [143:0] out_tdata;       // status, selected, past_all, first_line, last_line, merged_count
  logic         cfg_we = 0;
  logic         cfg_index = 0;
  logic [31:0]  cfg_wdata = '0;

  range_table_board board = new();
  int unsigned idle_cycles = 0;
  int unsigned in_beats = 0;
  int unsigned hold_off = 0;     // long receiver stall, counted here
  bit          hold_done = 0;

  always #5 clk = ~clk;

  line_range_selector dut (.*);

  // the packed struct lays the fields out lsb first in reverse order, so unpack by hand
  function automatic selection_t unpack_result(logic [143:0] d);
    selection_t r;
    r.status = d[1:0];
    r.selected = d[2];
    r.past_all = d[3];
    r.first_line = d[66:4];
    r.last_line = d[129:67];
    r.merged_count = d[136:130];
    return r;
  endfunction

  // sample handshakes at the edge, before the nonblocking updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        board.note_beat(in_tdata[1:0], in_tdata[64:2], in_tdata[127:65], in_tdata[190:128]);
        in_beats <= in_beats + 1;
      end
      if (out_tvalid && out_tready) board.check_result(unpack_result(out_tdata));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off while the adds stream in
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else if (!hold_done && in_beats >= 30) begin
      hold_done <= 1;
      hold_off <= 300;
      out_tready <= 0;
    end else begin
      case ($urandom_range(0, 3))
        0: out_tready <= ($urandom_range(0, 9) < 2);
        1: out_tready <= 1;
        default: out_tready <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [lrs_pkg::LineW-1:0] s,
                           logic [lrs_pkg::LineW-1:0] e, logic [lrs_pkg::LineW-1:0] ln);
    in_tvalid <= 1;
    in_tdata <= {1'b0, ln, e, s, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // random gaps between bursts
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_context(logic idx, logic [lrs_pkg::CtxW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.set_context(idx, val);
  endtask

  // mostly small lines near each other so ranges overlap, sometimes anywhere
  function automatic logic [lrs_pkg::LineW-1:0] pick_line();
    case ($urandom_range(0, 9))
      0: return lrs_pkg::LineW'({$urandom, $urandom} >> 1);
      1: return lrs_pkg::LineMax - lrs_pkg::LineW'($urandom_range(0, 40));
      2: return lrs_pkg::LineW'($urandom_range(0, 3));
      default: return lrs_pkg::LineW'($urandom_range(0, 600));
    endcase
  endfunction

  task automatic random_add();
    logic [lrs_pkg::LineW-1:0] s, e;
    s = pick_line();
    if ($urandom_range(0, 9) == 0) e = pick_line();   // may be a bad range
    else if ($urandom_range(0, 9) == 0) e = lrs_pkg::LineMax;
    else e = s + lrs_pkg::LineW'($urandom_range(0, 30));
    if (e < s && $urandom_range(0, 3) != 0) e = lrs_pkg::LineMax;
    send_beat(lrs_pkg::CmdAdd, s, e, pick_line());
  endtask

  task automatic random_query();
    send_beat(lrs_pkg::CmdQuery, pick_line(), pick_line(), pick_line());
  endtask

  initial begin
    int unsigned n, k, sent, ctx_sel;
    logic [lrs_pkg::CtxW-1:0] ctx_choices[4];

    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: query before finalize, empty finalize, bad ranges, extremes
    send_beat(lrs_pkg::CmdQuery, 0, 0, 5);
    send_beat(lrs_pkg::CmdFinal, 0, 0, 0);
    send_beat(lrs_pkg::CmdQuery, 0, 0, 0);
    send_beat(lrs_pkg::CmdQuery, 0, 0, lrs_pkg::LineMax);
    send_beat(lrs_pkg::CmdAdd, 0, 5, 0);
    send_beat(lrs_pkg::CmdAdd, 10, 9, 0);
    send_beat(lrs_pkg::CmdAdd, lrs_pkg::LineMax, lrs_pkg::LineMax, 0);
    send_beat(lrs_pkg::CmdAdd, 1, 1, 0);
    send_beat(lrs_pkg::CmdAdd, 20, 30, 0);
    send_beat(lrs_pkg::CmdAdd, 31, 40, 0);       // touches the previous range
    send_beat(lrs_pkg::CmdAdd, 5, 8, 0);
    send_beat(lrs_pkg::CmdQuery, 0, 0, 3);       // before finalize
    send_beat(lrs_pkg::CmdFinal, 0, 0, 0);
    send_beat(lrs_pkg::CmdQuery, 0, 0, 0);       // line zero
    send_beat(lrs_pkg::CmdQuery, 0, 0, 35);
    send_beat(lrs_pkg::CmdQuery, 0, 0, 12);
    send_beat(lrs_pkg::CmdQuery, 0, 0, lrs_pkg::LineMax);
    send_beat(lrs_pkg::CmdAdd, 100, 200, 0);     // add after finalize
    send_beat(lrs_pkg::CmdFinal, 0, 0, 0);
    send_beat(lrs_pkg::CmdFinal, 0, 0, 0);       // repeated finalize
    send_beat(lrs_pkg::CmdQuery, 0, 0, 201);
    send_beat(lrs_pkg::CmdClear, lrs_pkg::LineMax, lrs_pkg::LineMax, lrs_pkg::LineMax);
    // full table: 65 adds, 64 stored
    for (k = 0; k < 65; k++) begin
      send_beat(lrs_pkg::CmdAdd, lrs_pkg::LineW'(3 * k + 1), lrs_pkg::LineW'(3 * k + 1), 0);
    end
    send_beat(lrs_pkg::CmdFinal, 0, 0, 0);

    // queries back to back over the full table
    for (k = 0; k < 10; k++) send_beat(lrs_pkg::CmdQuery, 0, 0, lrs_pkg::LineW'(k * 20));
    drain_and_settle();

    ctx_choices[0] = '0;
    ctx_choices[1] = 32'hFFFF_FFFF;
    ctx_choices[2] = 32'd1;
    ctx_choices[3] = 32'd3;
    sent = 0;
    while (sent < 1700) begin
      ctx_sel = $urandom_range(0, 5);
      write_context(lrs_pkg::CfgBefore, ctx_sel < 4 ? ctx_choices[ctx_sel] : $urandom);
      ctx_sel = $urandom_range(0, 5);
      write_context(lrs_pkg::CfgAfter, ctx_sel < 4 ? ctx_choices[ctx_sel] : $urandom);
      // a well-formed session: clear, adds, finalize, queries, with some noise
      for (n = 0; n < 6; n++) begin
        if ($urandom_range(0, 4) != 0) begin
          send_beat(lrs_pkg::CmdClear, 0, 0, 0);
          sent++;
        end
        k = $urandom_range(0, 9) == 0 ? 66 : $urandom_range(0, 12);
        repeat (k) begin
          random_add();
          sent++;
        end
        if ($urandom_range(0, 7) == 0) begin
          random_query();
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          send_beat(lrs_pkg::CmdFinal, 0, 0, 0);
          sent++;
        end
        repeat ($urandom_range(4, 16)) begin
          random_query();
          sent++;
        end
      end
      drain_and_settle();
    end

    if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/lrs_pkg.sv
hdl/lrs_ram.sv
hdl/line_range_selector.sv
tb/testbench.sv
